@@ src/hashed_timing_wheel_defines.svh @@
// Assertion macros used by the checker file of the timing wheel.
`ifndef HASHED_TIMING_WHEEL_DEFINES_SVH
`define HASHED_TIMING_WHEEL_DEFINES_SVH

// Checks that cond holds in the same cycle as trig.
`define HTW_ASSERT_NOW(lbl, clk, rstn, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |-> (cond)) \
        else $error("htw check failed");

// Checks that cond holds in the cycle after trig.
`define HTW_ASSERT_NEXT(lbl, clk, rstn, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) \
        else $error("htw check failed");

`endif

@@ src/htw_pkg.sv @@
// Package with the item type and the codes of the hashed timing wheel.
package htw_pkg;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] KIND_ADDED  = 2'd0;
    localparam logic [1:0] KIND_FIRED  = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam int MAX_RESULTS = 64;

    typedef struct packed {
        logic        op;
        logic [23:0] interval;
        logic [31:0] tag;
    } item_t;

endpackage

@@ src/hashed_timing_wheel.sv @@
// Top level of the hashed timing wheel.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    opcode, interval_ms, tag
//   m_       out        m_valid/m_ready    kind, timer_id, tag_out, fire_time, last
//
// An add with a free entry passes the dispatch, modulo, slot, head read, head data and output
// states, plus a link write when its slot has entries; a tick walks the entries in its slot.
// The slot of an add comes from a reciprocal multiplication and a wrap correction.
// After reset the slot head memory is cleared before items are taken.
// A stalled result holds the engine; the two-entry queue keeps accepting until it is full.
module hashed_timing_wheel #(
    parameter int SLOTS      = 256,
    parameter int MAX_TIMERS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [23:0] s_interval_ms,
    input  logic [31:0] s_tag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [31:0] m_timer_id,
    output logic [31:0] m_tag_out,
    output logic [31:0] m_fire_time,
    output logic        m_last
);

    logic           q_valid;
    logic           q_ready;
    htw_pkg::item_t q_item;

    htw_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_interval_ms (s_interval_ms),
        .s_tag         (s_tag),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    htw_engine #(.SLOTS(SLOTS), .MAX_TIMERS(MAX_TIMERS)) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_timer_id  (m_timer_id),
        .m_tag_out   (m_tag_out),
        .m_fire_time (m_fire_time),
        .m_last      (m_last)
    );

endmodule

@@ src/htw_ram.sv @@
// Generic single write port RAM with one registered read port.
module htw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/htw_queue.sv @@
// Two-entry item queue between the front and the engine.
module htw_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  htw_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output htw_pkg::item_t  head_item
);

    htw_pkg::item_t slot_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head_item = slot_reg[rp_reg];

    always_comb begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            slot_reg[wp_reg] <= push_item;
        end
    end

endmodule

@@ src/htw_front.sv @@
// Front end: accepts items, normalises the interval and queues them.
module htw_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_opcode,
    input  logic [23:0]     s_interval_ms,
    input  logic [31:0]     s_tag,
    output logic            q_valid,
    input  logic            q_ready,
    output htw_pkg::item_t  q_item
);

    htw_pkg::item_t in_item;
    logic           q_full;

    always_comb begin
        in_item.op       = s_opcode;
        in_item.interval = (s_interval_ms == 24'd0) ? 24'd1 : s_interval_ms;
        in_item.tag      = s_tag;
        if (s_opcode == htw_pkg::OP_TICK) begin
            in_item.interval = 24'd0;
            in_item.tag      = 32'd0;
        end
    end

    assign s_ready = !q_full;

    htw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid && !q_full),
        .push_item (in_item),
        .full      (q_full),
        .pop       (q_valid && q_ready),
        .not_empty (q_valid),
        .head_item (q_item)
    );

endmodule

@@ src/htw_engine.sv @@
// Engine: executes adds and slot walks against the wheel memories.
module htw_engine #(
    parameter int SLOTS      = 256,
    parameter int MAX_TIMERS = 64
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  htw_pkg::item_t  q_item,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [1:0]      m_kind,
    output logic [31:0]     m_timer_id,
    output logic [31:0]     m_tag_out,
    output logic [31:0]     m_fire_time,
    output logic            m_last
);

    localparam int SW  = $clog2(SLOTS);
    localparam int IW  = $clog2(MAX_TIMERS);
    localparam int EW  = $clog2(MAX_TIMERS + 1);
    localparam int FW  = $clog2(htw_pkg::MAX_RESULTS + 1);
    localparam int KSH = 24 + SW;
    localparam logic [EW-1:0] NIL = EW'(MAX_TIMERS);
    localparam logic [SW:0] SLOTS_W = (SW + 1)'(SLOTS);
    localparam logic [SW:0] C32 = (SW + 1)'((64'd1 << 32) % 64'(SLOTS));
    localparam logic [24:0] RECIP =
        25'(((64'd1 << KSH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));
    localparam logic [23:0] SLOTS24 = 24'(SLOTS);
    localparam logic [FW-1:0] FIRE_CAP = FW'(htw_pkg::MAX_RESULTS);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_MOD   = 4'd3;
    localparam logic [3:0] S_RDH   = 4'd4;
    localparam logic [3:0] S_HDATA = 4'd5;
    localparam logic [3:0] S_ADDW2 = 4'd6;
    localparam logic [3:0] S_ADDO  = 4'd7;
    localparam logic [3:0] S_WIS   = 4'd8;
    localparam logic [3:0] S_WDATA = 4'd9;
    localparam logic [3:0] S_WEND  = 4'd10;
    localparam logic [3:0] S_SLOT  = 4'd11;

    logic [3:0]            state_reg, state_next;
    logic [31:0]           now_reg, now_next;
    logic [31:0]           idc_reg, idc_next;
    logic [MAX_TIMERS-1:0] busy_reg, busy_next;
    htw_pkg::item_t        item_reg, item_next;
    logic [IW-1:0]         e_reg, e_next;
    logic [48:0]           prod_reg, prod_next;
    logic                  wrap_reg, wrap_next;
    logic [SW-1:0]         rem_reg, rem_next;
    logic [SW-1:0]         nslot_reg, nslot_next;
    logic [SW-1:0]         slot_reg, slot_next;
    logic [SW-1:0]         clr_reg, clr_next;
    logic [EW-1:0]         cur_reg, cur_next;
    logic [EW-1:0]         prev_reg, prev_next;
    logic [IW-1:0]         tail_reg, tail_next;
    logic [FW-1:0]         fcnt_reg, fcnt_next;
    logic                  pend_v_reg, pend_v_next;
    logic [31:0]           pend_id_reg, pend_id_next;
    logic [31:0]           pend_tag_reg, pend_tag_next;
    logic [31:0]           pend_dl_reg, pend_dl_next;
    logic                  mv_valid_reg, mv_valid_next;
    logic [1:0]            mk_reg, mk_next;
    logic [31:0]           mid_reg, mid_next;
    logic [31:0]           mtag_reg, mtag_next;
    logic [31:0]           mft_reg, mft_next;
    logic                  ml_reg, ml_next;

    logic          free_any;
    logic [IW-1:0] free_idx;
    logic          out_free;
    logic          fire;
    logic [32:0]   dl_sum;
    logic [23:0]   quot;
    logic [23:0]   ivrem;
    logic [SW:0]   slot_sum, slot_red, slot_adj;
    logic [SW-1:0] nslot_inc, tick_slot;

    logic          head_we, head_re, tail_we, tail_re, link_we, ent_we, ent_re;
    logic [SW-1:0] head_wa, tail_wa;
    logic [EW-1:0] head_wd, link_wd;
    logic [IW-1:0] tail_wd, link_wa, ent_ra;
    logic [EW-1:0] head_rd, link_rd;
    logic [IW-1:0] tail_rd;
    logic [31:0]   dl_rd, tag_rd, id_rd;

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    // The slot of a deadline is (now mod SLOTS + interval mod SLOTS) mod SLOTS, corrected
    // by 2^32 mod SLOTS when the deadline wraps; the interval remainder uses a reciprocal.
    assign out_free  = !mv_valid_reg || m_ready;
    assign q_ready   = (state_reg == S_IDLE);
    assign fire      = (dl_rd == now_reg);
    assign dl_sum    = {1'b0, now_reg} + {9'd0, item_reg.interval};
    assign quot      = 24'(prod_reg >> KSH);
    assign ivrem     = item_reg.interval - quot * SLOTS24;
    assign slot_sum  = {1'b0, nslot_reg} + {1'b0, rem_reg};
    assign slot_red  = (slot_sum >= SLOTS_W) ? (slot_sum - SLOTS_W) : slot_sum;
    assign slot_adj  = !wrap_reg ? slot_red
                     : (slot_red >= C32) ? (slot_red - C32)
                     : (slot_red + SLOTS_W - C32);
    assign nslot_inc = (nslot_reg == SW'(SLOTS - 1)) ? '0 : (nslot_reg + 1'b1);
    assign tick_slot = (now_reg == 32'hFFFF_FFFF) ? '0 : nslot_inc;

    always_comb begin
        state_next    = state_reg;
        now_next      = now_reg;
        idc_next      = idc_reg;
        busy_next     = busy_reg;
        item_next     = item_reg;
        e_next        = e_reg;
        prod_next     = prod_reg;
        wrap_next     = wrap_reg;
        rem_next      = rem_reg;
        nslot_next    = nslot_reg;
        slot_next     = slot_reg;
        clr_next      = clr_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        tail_next     = tail_reg;
        fcnt_next     = fcnt_reg;
        pend_v_next   = pend_v_reg;
        pend_id_next  = pend_id_reg;
        pend_tag_next = pend_tag_reg;
        pend_dl_next  = pend_dl_reg;
        mv_valid_next = mv_valid_reg && !m_ready;
        mk_next       = mk_reg;
        mid_next      = mid_reg;
        mtag_next     = mtag_reg;
        mft_next      = mft_reg;
        ml_next       = ml_reg;
        head_we = 1'b0; head_wa = slot_reg; head_wd = NIL; head_re = 1'b0;
        tail_we = 1'b0; tail_wa = slot_reg; tail_wd = e_reg; tail_re = 1'b0;
        link_we = 1'b0; link_wa = e_reg; link_wd = NIL;
        ent_we  = 1'b0; ent_re = 1'b0; ent_ra = cur_reg[IW-1:0];

        case (state_reg)
            S_CLEAR: begin
                head_we  = 1'b1;
                head_wa  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SW'(SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (q_valid) begin
                    item_next  = q_item;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                if (item_reg.op == htw_pkg::OP_TICK) begin
                    now_next   = now_reg + 32'd1;
                    nslot_next = tick_slot;
                    slot_next  = tick_slot;
                    state_next = S_RDH;
                end else if (free_any) begin
                    e_next     = free_idx;
                    prod_next  = 49'(item_reg.interval) * 49'(RECIP);
                    wrap_next  = dl_sum[32];
                    state_next = S_MOD;
                end else if (out_free) begin
                    mv_valid_next = 1'b1;
                    mk_next    = htw_pkg::KIND_REJECT;
                    mid_next   = '0;
                    mtag_next  = '0;
                    mft_next   = '0;
                    ml_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MOD: begin
                rem_next   = ivrem[SW-1:0];
                state_next = S_SLOT;
            end
            S_SLOT: begin
                slot_next  = slot_adj[SW-1:0];
                state_next = S_RDH;
            end
            S_RDH: begin
                head_re    = 1'b1;
                tail_re    = 1'b1;
                state_next = S_HDATA;
            end
            S_HDATA: begin
                if (item_reg.op == htw_pkg::OP_TICK) begin
                    cur_next   = head_rd;
                    prev_next  = NIL;
                    tail_next  = tail_rd;
                    fcnt_next  = '0;
                    state_next = S_WIS;
                end else begin
                    ent_we    = 1'b1;
                    link_we   = 1'b1;
                    tail_we   = 1'b1;
                    tail_next = tail_rd;
                    busy_next[e_reg] = 1'b1;
                    if (head_rd == NIL) begin
                        head_we    = 1'b1;
                        head_wd    = EW'(e_reg);
                        state_next = S_ADDO;
                    end else begin
                        state_next = S_ADDW2;
                    end
                end
            end
            S_ADDW2: begin
                link_we    = 1'b1;
                link_wa    = tail_reg;
                link_wd    = EW'(e_reg);
                state_next = S_ADDO;
            end
            S_ADDO: begin
                if (out_free) begin
                    mv_valid_next = 1'b1;
                    mk_next    = htw_pkg::KIND_ADDED;
                    mid_next   = idc_reg + 32'd1;
                    mtag_next  = '0;
                    mft_next   = now_reg + {8'd0, item_reg.interval};
                    ml_next    = 1'b1;
                    idc_next   = idc_reg + 32'd1;
                    state_next = S_IDLE;
                end
            end
            S_WIS: begin
                if ((cur_reg == NIL) || (fcnt_reg == FIRE_CAP)) begin
                    state_next = S_WEND;
                end else begin
                    ent_re     = 1'b1;
                    state_next = S_WDATA;
                end
            end
            S_WDATA: begin
                if (!fire) begin
                    prev_next  = cur_reg;
                    cur_next   = link_rd;
                    state_next = S_WIS;
                end else if (!pend_v_reg || out_free) begin
                    if (pend_v_reg) begin
                        mv_valid_next = 1'b1;
                        mk_next   = htw_pkg::KIND_FIRED;
                        mid_next  = pend_id_reg;
                        mtag_next = pend_tag_reg;
                        mft_next  = pend_dl_reg;
                        ml_next   = 1'b0;
                    end
                    pend_v_next   = 1'b1;
                    pend_id_next  = id_rd;
                    pend_tag_next = tag_rd;
                    pend_dl_next  = dl_rd;
                    fcnt_next     = fcnt_reg + 1'b1;
                    if (prev_reg == NIL) begin
                        head_we = 1'b1;
                        head_wd = link_rd;
                    end else begin
                        link_we = 1'b1;
                        link_wa = prev_reg[IW-1:0];
                        link_wd = link_rd;
                    end
                    if ((EW'(tail_reg) == cur_reg) && (prev_reg != NIL)) begin
                        tail_we   = 1'b1;
                        tail_wd   = prev_reg[IW-1:0];
                        tail_next = prev_reg[IW-1:0];
                    end
                    busy_next[cur_reg[IW-1:0]] = 1'b0;
                    cur_next   = link_rd;
                    state_next = S_WIS;
                end
            end
            S_WEND: begin
                if (!pend_v_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    mv_valid_next = 1'b1;
                    mk_next     = htw_pkg::KIND_FIRED;
                    mid_next    = pend_id_reg;
                    mtag_next   = pend_tag_reg;
                    mft_next    = pend_dl_reg;
                    ml_next     = 1'b1;
                    pend_v_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            now_reg      <= '0;
            nslot_reg    <= '0;
            idc_reg      <= '0;
            busy_reg     <= '0;
            pend_v_reg   <= 1'b0;
            mv_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            now_reg      <= now_next;
            nslot_reg    <= nslot_next;
            idc_reg      <= idc_next;
            busy_reg     <= busy_next;
            pend_v_reg   <= pend_v_next;
            mv_valid_reg <= mv_valid_next;
        end
        item_reg     <= item_next;
        e_reg        <= e_next;
        prod_reg     <= prod_next;
        wrap_reg     <= wrap_next;
        rem_reg      <= rem_next;
        slot_reg     <= slot_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        tail_reg     <= tail_next;
        fcnt_reg     <= fcnt_next;
        pend_id_reg  <= pend_id_next;
        pend_tag_reg <= pend_tag_next;
        pend_dl_reg  <= pend_dl_next;
        mk_reg       <= mk_next;
        mid_reg      <= mid_next;
        mtag_reg     <= mtag_next;
        mft_reg      <= mft_next;
        ml_reg       <= ml_next;
    end

    assign m_valid     = mv_valid_reg;
    assign m_kind      = mk_reg;
    assign m_timer_id  = mid_reg;
    assign m_tag_out   = mtag_reg;
    assign m_fire_time = mft_reg;
    assign m_last      = ml_reg;

    htw_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_head (
        .aclk(aclk), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
        .rd_en(head_re), .rd_addr(slot_reg), .rd_data(head_rd)
    );

    htw_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_tail (
        .aclk(aclk), .wr_en(tail_we), .wr_addr(tail_wa), .wr_data(tail_wd),
        .rd_en(tail_re), .rd_addr(slot_reg), .rd_data(tail_rd)
    );

    htw_ram #(.WIDTH(EW), .DEPTH(MAX_TIMERS)) u_link (
        .aclk(aclk), .wr_en(link_we), .wr_addr(link_wa), .wr_data(link_wd),
        .rd_en(ent_re), .rd_addr(ent_ra), .rd_data(link_rd)
    );

    htw_ram #(.WIDTH(32), .DEPTH(MAX_TIMERS)) u_deadline (
        .aclk(aclk), .wr_en(ent_we), .wr_addr(e_reg),
        .wr_data(now_reg + {8'd0, item_reg.interval}),
        .rd_en(ent_re), .rd_addr(ent_ra), .rd_data(dl_rd)
    );

    htw_ram #(.WIDTH(32), .DEPTH(MAX_TIMERS)) u_tag (
        .aclk(aclk), .wr_en(ent_we), .wr_addr(e_reg), .wr_data(item_reg.tag),
        .rd_en(ent_re), .rd_addr(ent_ra), .rd_data(tag_rd)
    );

    htw_ram #(.WIDTH(32), .DEPTH(MAX_TIMERS)) u_id (
        .aclk(aclk), .wr_en(ent_we), .wr_addr(e_reg), .wr_data(idc_reg + 32'd1),
        .rd_en(ent_re), .rd_addr(ent_ra), .rd_data(id_rd)
    );

endmodule

@@ src/htw_checker.sv @@
// Port checker for the hashed timing wheel and its bind statement.
`include "hashed_timing_wheel_defines.svh"

module htw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic [31:0] m_timer_id,
    input logic [31:0] m_tag_out,
    input logic [31:0] m_fire_time,
    input logic        m_last
);

    `HTW_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_kind) && $stable(m_timer_id))
    `HTW_ASSERT_NOW(a_kind, aclk, aresetn, m_valid, m_kind != 2'd3)
    `HTW_ASSERT_NOW(a_added, aclk, aresetn, m_valid && m_kind == htw_pkg::KIND_ADDED, m_last && m_tag_out == 32'd0)
    `HTW_ASSERT_NOW(a_reject, aclk, aresetn, m_valid && m_kind == htw_pkg::KIND_REJECT, m_last && m_timer_id == 32'd0 && m_fire_time == 32'd0)

endmodule

bind hashed_timing_wheel htw_checker u_htw_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_kind      (m_kind),
    .m_timer_id  (m_timer_id),
    .m_tag_out   (m_tag_out),
    .m_fire_time (m_fire_time),
    .m_last      (m_last)
);
